>>> sv/cpr_pkg.sv
package cpr_pkg;

  // Result status codes
  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_FILL     = 3'd1;
  localparam logic [2:0] ST_REPLACE  = 3'd2;
  localparam logic [2:0] ST_NOVICTIM = 3'd3;
  localparam logic [2:0] ST_RELEASE  = 3'd4;

  // One frame table entry as held in the RAM
  typedef struct packed {
    logic        valid;
    logic        refb;
    logic [7:0]  proc;
    logic [15:0] vpage;
  } frame_entry_t;

  localparam int ENTRY_W = $bits(frame_entry_t);

  // Operation applied to the entry under the shared evaluation unit
  typedef enum logic [1:0] {
    OP_HIT,
    OP_REL,
    OP_FILL,
    OP_SWEEP
  } op_t;

  typedef struct packed {
    logic         wr;
    logic         found;
    frame_entry_t wr_data;
  } eval_act_t;

endpackage

>>> sv/cpr_if.sv
interface cpr_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  proc_id;
  logic [15:0] vpage;
  logic        resident;
  logic [7:0]  frame_in;

  modport source (output valid, mode, proc_id, vpage, resident, frame_in, input ready);
  modport sink   (input valid, mode, proc_id, vpage, resident, frame_in, output ready);
endinterface

interface cpr_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  frame_out;
  logic        evicted_valid;
  logic [7:0]  evicted_proc;
  logic [15:0] evicted_vpage;

  modport source (output valid, status, frame_out, evicted_valid, evicted_proc,
                  evicted_vpage, input ready);
  modport sink   (input valid, status, frame_out, evicted_valid, evicted_proc,
                  evicted_vpage, output ready);
endinterface

>>> sv/cpr_ram.sv
module cpr_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/cpr_frame_eval.sv
module cpr_frame_eval
  import cpr_pkg::*;
(
  input  op_t          op,
  input  frame_entry_t ent,
  input  logic [7:0]   proc_id,
  input  logic [15:0]  vpage,
  output eval_act_t    act
);

  frame_entry_t fresh;
  logic         cand;

  always_comb begin
    fresh       = '{valid: 1'b1, refb: 1'b1, proc: proc_id, vpage: vpage};
    cand        = ent.valid && (ent.proc != proc_id);
    act.wr      = 1'b0;
    act.found   = 1'b0;
    act.wr_data = ent;
    case (op)
      OP_HIT: begin
        act.wr           = ent.valid;
        act.found        = 1'b1;
        act.wr_data.refb = 1'b1;
      end
      OP_REL: begin
        act.wr            = ent.valid;
        act.found         = 1'b1;
        act.wr_data.valid = 1'b0;
        act.wr_data.refb  = 1'b0;
      end
      OP_FILL: begin
        act.found   = !ent.valid;
        act.wr      = !ent.valid;
        act.wr_data = fresh;
      end
      OP_SWEEP: begin
        // second chance: clear a set reference bit, evict on a clear one
        act.wr    = cand;
        act.found = cand && !ent.refb;
        if (ent.refb) begin
          act.wr_data.refb = 1'b0;
        end else begin
          act.wr_data = fresh;
        end
      end
      default: begin
        act.wr = 1'b0;
      end
    endcase
  end

endmodule

>>> sv/clock_page_replacement_unit.sv
// Hit/release: the entry is read, written back in S_RMW, then the result is registered
// from S_DONE (the RAM is skipped if frame_in is out of range). Miss with a free frame:
// frames are scanned from frame 0 up to the lowest free one. Miss without a free frame:
// up to two passes; the frame table RAM is read one frame per cycle and one entry is evaluated per cycle.
// In ready returns the cycle after the result loads into the output register.
// Synchronous reset, then a clearing pass over all NUM_FRAMES entries with in ready low.
module clock_page_replacement_unit
  import cpr_pkg::*;
#(
  parameter int NUM_FRAMES = 256
) (
  input logic      clk,
  input logic      rst_n,
  cpr_req_if.sink  in_req,
  cpr_rsp_if.source out_rsp
);

  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CW = $clog2(NUM_FRAMES + 1);
  localparam logic [FW-1:0] LAST_IDX = FW'(NUM_FRAMES - 1);
  localparam logic [CW-1:0] FREE_RST = CW'(NUM_FRAMES);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [FW-1:0] idx_r, idx_nxt;
  logic          pass_r, pass_nxt;
  op_t           op_r, op_nxt;
  logic [7:0]    proc_r, proc_nxt;
  logic [15:0]   vpage_r, vpage_nxt;
  logic [CW-1:0] free_r, free_nxt;

  logic [2:0]    res_status_r, res_status_nxt;
  logic [7:0]    res_frame_r, res_frame_nxt;
  logic          res_ev_r, res_ev_nxt;
  logic [7:0]    res_ep_r, res_ep_nxt;
  logic [15:0]   res_evp_r, res_evp_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [7:0]    out_frame_r, out_frame_nxt;
  logic          out_ev_r, out_ev_nxt;
  logic [7:0]    out_ep_r, out_ep_nxt;
  logic [15:0]   out_evp_r, out_evp_nxt;

  logic               ram_wr_en, ram_rd_en;
  logic [FW-1:0]      ram_wr_addr, ram_rd_addr;
  logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;
  frame_entry_t       ent;
  eval_act_t          act;

  logic          accept;
  logic [31:0]   fin32, idx32;
  logic          fin_ok;
  logic [FW-1:0] fin_idx, next_idx;

  cpr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_FRAMES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign ent = frame_entry_t'(ram_rd_data);

  cpr_frame_eval u_eval (
    .op      (op_r),
    .ent     (ent),
    .proc_id (proc_r),
    .vpage   (vpage_r),
    .act     (act)
  );

  assign in_req.ready          = (state_r == S_IDLE);
  assign accept                = in_req.valid && in_req.ready;
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.frame_out     = out_frame_r;
  assign out_rsp.evicted_valid = out_ev_r;
  assign out_rsp.evicted_proc  = out_ep_r;
  assign out_rsp.evicted_vpage = out_evp_r;

  assign fin32    = {24'd0, in_req.frame_in};
  assign fin_ok   = fin32 < 32'(NUM_FRAMES);
  assign fin_idx  = fin32[FW-1:0];
  assign idx32    = 32'(idx_r);
  assign next_idx = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pass_nxt       = pass_r;
    op_nxt         = op_r;
    proc_nxt       = proc_r;
    vpage_nxt      = vpage_r;
    free_nxt       = free_r;
    res_status_nxt = res_status_r;
    res_frame_nxt  = res_frame_r;
    res_ev_nxt     = res_ev_r;
    res_ep_nxt     = res_ep_r;
    res_evp_nxt    = res_evp_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_frame_nxt  = out_frame_r;
    out_ev_nxt     = out_ev_r;
    out_ep_nxt     = out_ep_r;
    out_evp_nxt    = out_evp_r;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = idx_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = idx_r;
    ram_wr_data    = act.wr_data;

    case (state_r)
      S_CLR: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = '0;
        idx_nxt     = next_idx;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          proc_nxt       = in_req.proc_id;
          vpage_nxt      = in_req.vpage;
          res_ev_nxt     = 1'b0;
          res_ep_nxt     = '0;
          res_evp_nxt    = '0;
          res_frame_nxt  = in_req.frame_in;
          res_status_nxt = in_req.mode ? ST_RELEASE : ST_HIT;
          if (in_req.mode || in_req.resident) begin
            op_nxt = in_req.mode ? OP_REL : OP_HIT;
            if (fin_ok) begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = fin_idx;
              idx_nxt     = fin_idx;
              state_nxt   = S_RMW;
            end else begin
              state_nxt = S_DONE;
            end
          end else begin
            op_nxt      = (free_r != '0) ? OP_FILL : OP_SWEEP;
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            idx_nxt     = '0;
            pass_nxt    = 1'b0;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_RMW: begin
        ram_wr_en = act.wr;
        if (op_r == OP_REL && ent.valid) begin
          free_nxt = free_r + 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        // fetch the next frame while this one is evaluated
        ram_rd_en   = 1'b1;
        ram_rd_addr = next_idx;
        ram_wr_en   = act.wr;
        if (act.found) begin
          res_frame_nxt = idx32[7:0];
          state_nxt     = S_DONE;
          if (op_r == OP_FILL) begin
            res_status_nxt = ST_FILL;
            free_nxt       = free_r - 1'b1;
          end else begin
            res_status_nxt = ST_REPLACE;
            res_ev_nxt     = 1'b1;
            res_ep_nxt     = ent.proc;
            res_evp_nxt    = ent.vpage;
          end
        end else if (idx_r == LAST_IDX) begin
          idx_nxt = '0;
          if (pass_r) begin
            res_status_nxt = ST_NOVICTIM;
            res_frame_nxt  = '0;
            state_nxt      = S_DONE;
          end else begin
            pass_nxt = 1'b1;
          end
        end else begin
          idx_nxt = next_idx;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_frame_nxt  = res_frame_r;
          out_ev_nxt     = res_ev_r;
          out_ep_nxt     = res_ep_r;
          out_evp_nxt    = res_evp_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      pass_r      <= 1'b0;
      op_r        <= OP_HIT;
      free_r      <= FREE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pass_r      <= pass_nxt;
      op_r        <= op_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
    proc_r       <= proc_nxt;
    vpage_r      <= vpage_nxt;
    res_status_r <= res_status_nxt;
    res_frame_r  <= res_frame_nxt;
    res_ev_r     <= res_ev_nxt;
    res_ep_r     <= res_ep_nxt;
    res_evp_r    <= res_evp_nxt;
    out_status_r <= out_status_nxt;
    out_frame_r  <= out_frame_nxt;
    out_ev_r     <= out_ev_nxt;
    out_ep_r     <= out_ep_nxt;
    out_evp_r    <= out_evp_nxt;
  end

endmodule

>>> sv/cpr_checker.sv
module cpr_checker
  import cpr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [7:0]  frame_out,
  input logic        ev_valid,
  input logic [7:0]  ev_proc,
  input logic [15:0] ev_vpage
);

  // one item at a time: the block is busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(frame_out))
    else $error("result beat changed while stalled");

  a_evict_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ev_valid == (status == ST_REPLACE)))
    else $error("evicted flag disagrees with status");

  a_no_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_NOVICTIM) |-> frame_out == 8'd0 && ev_proc == 8'd0
      && ev_vpage == 16'd0)
    else $error("no-victim result carries nonzero fields");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status == ST_HIT || status == ST_FILL || status == ST_REPLACE
      || status == ST_NOVICTIM || status == ST_RELEASE)
    else $error("undefined status code");

endmodule

bind clock_page_replacement_unit cpr_checker u_cpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .status    (out_rsp.status),
  .frame_out (out_rsp.frame_out),
  .ev_valid  (out_rsp.evicted_valid),
  .ev_proc   (out_rsp.evicted_proc),
  .ev_vpage  (out_rsp.evicted_vpage)
);

>>> tb/clock_page_replacement_unit_tb.sv
`timescale 1ns / 100ps

module clock_page_replacement_unit_tb
  import cpr_pkg::*;
();

  localparam int NUM_FRAMES  = 256;
  localparam int MAIN_ITEMS  = 900;
  localparam int HOLD_AT     = 450;
  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 2 * NUM_FRAMES + 8;
  localparam logic [7:0] SOLO_PROC  = 8'hC3;
  localparam logic [7:0] OTHER_PROC = 8'h3C;

  typedef struct packed {
    logic        mode;
    logic [7:0]  proc;
    logic [15:0] vpage;
    logic        resident;
    logic [7:0]  frame;
  } page_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  frame;
    logic        evicted;
    logic [7:0]  ev_proc;
    logic [15:0] ev_vpage;
  } page_rsp_t;

  typedef struct packed {
    page_req_t req;
    logic      typed;
    page_rsp_t rsp;
  } page_row_t;

  logic clk;
  logic rst_n;

  cpr_req_if req_if ();
  cpr_rsp_if rsp_if ();

  clock_page_replacement_unit #(
    .NUM_FRAMES(NUM_FRAMES)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_rsp(rsp_if)
  );

  // Frame table as the block should hold it
  logic        pt_valid [NUM_FRAMES];
  logic        pt_ref   [NUM_FRAMES];
  logic [7:0]  pt_proc  [NUM_FRAMES];
  logic [15:0] pt_vpage [NUM_FRAMES];
  int          pt_free;

  page_rsp_t pending_rsp [$];
  page_row_t page_rows [$];

  int  mismatches = 0;
  int  beats_sent = 0;
  int  beats_seen = 0;
  int  status_seen [0:7];
  bit  calm = 1'b0;
  int  stuck = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic page_rsp_t place_page(input page_req_t rq);
    page_rsp_t rs;
    int        i;
    int        f;
    rs = '0;
    rs.frame = rq.frame;
    if (rq.mode) begin
      rs.status = ST_RELEASE;
      if (pt_valid[rq.frame]) begin
        pt_valid[rq.frame] = 1'b0;
        pt_ref[rq.frame] = 1'b0;
        pt_free++;
      end
      return rs;
    end
    if (rq.resident) begin
      rs.status = ST_HIT;
      if (pt_valid[rq.frame]) pt_ref[rq.frame] = 1'b1;
      return rs;
    end
    if (pt_free > 0) begin
      for (f = 0; f < NUM_FRAMES; f++) begin
        if (!pt_valid[f]) begin
          pt_valid[f] = 1'b1;
          pt_ref[f] = 1'b1;
          pt_proc[f] = rq.proc;
          pt_vpage[f] = rq.vpage;
          pt_free--;
          rs.status = ST_FILL;
          rs.frame = f[7:0];
          return rs;
        end
      end
    end
    // second chance: up to two passes from frame 0, own frames skipped
    for (i = 0; i < 2 * NUM_FRAMES; i++) begin
      f = i % NUM_FRAMES;
      if (pt_valid[f] && pt_proc[f] != rq.proc) begin
        if (pt_ref[f]) begin
          pt_ref[f] = 1'b0;
        end else begin
          rs.status = ST_REPLACE;
          rs.frame = f[7:0];
          rs.evicted = 1'b1;
          rs.ev_proc = pt_proc[f];
          rs.ev_vpage = pt_vpage[f];
          pt_ref[f] = 1'b1;
          pt_proc[f] = rq.proc;
          pt_vpage[f] = rq.vpage;
          return rs;
        end
      end
    end
    rs.status = ST_NOVICTIM;
    rs.frame = 8'd0;
    return rs;
  endfunction

  function automatic page_req_t rand_req();
    page_req_t rq;
    rq.mode = 1'($urandom_range(0, 1));
    rq.proc = 8'($urandom_range(0, 255));
    rq.vpage = 16'($urandom_range(0, 65535));
    rq.resident = 1'($urandom_range(0, 1));
    rq.frame = 8'($urandom_range(0, 255));
    return rq;
  endfunction

  function automatic logic [7:0] pick_held_frame();
    int start;
    int k;
    start = $urandom_range(0, NUM_FRAMES - 1);
    for (k = 0; k < NUM_FRAMES; k++) begin
      if (pt_valid[(start + k) % NUM_FRAMES]) return 8'((start + k) % NUM_FRAMES);
    end
    return start[7:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  task automatic add_row(input page_req_t rq, input logic typed, input logic [2:0] st,
                         input logic [7:0] fr);
    page_row_t row;
    row.req = rq;
    row.typed = typed;
    row.rsp = '0;
    row.rsp.status = st;
    row.rsp.frame = fr;
    page_rows.push_back(row);
  endtask

  // Offer one beat; predict and queue its result once it is taken
  task automatic offer_page(input page_req_t rq, input logic typed, input page_rsp_t typed_rsp);
    int        gap;
    page_rsp_t rs;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= rq.mode;
    req_if.proc_id  <= rq.proc;
    req_if.vpage    <= rq.vpage;
    req_if.resident <= rq.resident;
    req_if.frame_in <= rq.frame;
    do @(posedge clk); while (!req_if.ready);
    rs = place_page(rq);
    pending_rsp.push_back(typed ? typed_rsp : rs);
    beats_sent++;
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  page_rsp_t got_rsp;
  page_rsp_t want_rsp;

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got_rsp = {rsp_if.status, rsp_if.frame_out, rsp_if.evicted_valid,
                 rsp_if.evicted_proc, rsp_if.evicted_vpage};
      beats_seen++;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, actual 0x%0h", $time, got_rsp);
      end else begin
        want_rsp = pending_rsp.pop_front();
        status_seen[want_rsp.status]++;
        check_field("status", want_rsp.status, got_rsp.status);
        check_field("frame_out", want_rsp.frame, got_rsp.frame);
        check_field("evicted_valid", want_rsp.evicted, got_rsp.evicted);
        check_field("evicted_proc", want_rsp.ev_proc, got_rsp.ev_proc);
        check_field("evicted_vpage", want_rsp.ev_vpage, got_rsp.ev_vpage);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off while the sender keeps going
  initial begin
    int  stall;
    int  r;
    bit  held;
    stall = 0;
    held = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && beats_sent >= HOLD_AT) begin
        held = 1'b1;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && !calm) begin
        r = $urandom_range(0, 99);
        if (r < 12) stall = $urandom_range(1, 3);
        else if (r < 14) stall = $urandom_range(4, 12);
        else if (r < 15) stall = $urandom_range(20, 80);
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) stuck = 0;
    else stuck = stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STUCK_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    page_req_t rq;
    page_row_t row;
    int        k;
    int        r;
    int        f;

    for (k = 0; k < NUM_FRAMES; k++) begin
      pt_valid[k] = 1'b0;
      pt_ref[k] = 1'b0;
      pt_proc[k] = '0;
      pt_vpage[k] = '0;
    end
    pt_free = NUM_FRAMES;
    for (k = 0; k < 8; k++) status_seen[k] = 0;

    req_if.valid    <= 1'b0;
    req_if.mode     <= 1'b0;
    req_if.proc_id  <= '0;
    req_if.vpage    <= '0;
    req_if.resident <= 1'b0;
    req_if.frame_in <= '0;
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: hits and releases of unused frames, fills from frame 0 up
    add_row({1'b0, 8'h00, 16'h0000, 1'b1, 8'h00}, 1'b1, ST_HIT, 8'h00);
    add_row({1'b0, 8'hFF, 16'hFFFF, 1'b1, 8'hFF}, 1'b1, ST_HIT, 8'hFF);
    add_row({1'b1, 8'h00, 16'h0000, 1'b0, 8'h00}, 1'b1, ST_RELEASE, 8'h00);
    add_row({1'b1, 8'hFF, 16'hFFFF, 1'b1, 8'hFF}, 1'b1, ST_RELEASE, 8'hFF);
    add_row({1'b0, 8'h00, 16'h0000, 1'b0, 8'hAA}, 1'b1, ST_FILL, 8'h00);
    add_row({1'b0, 8'hFF, 16'hFFFF, 1'b0, 8'hFF}, 1'b1, ST_FILL, 8'h01);
    add_row({1'b0, 8'h5A, 16'h8001, 1'b0, 8'h55}, 1'b1, ST_FILL, 8'h02);
    add_row({1'b0, 8'h12, 16'h0F0F, 1'b1, 8'h01}, 1'b1, ST_HIT, 8'h01);
    add_row({1'b1, 8'h34, 16'hF0F0, 1'b0, 8'h01}, 1'b1, ST_RELEASE, 8'h01);
    add_row({1'b0, 8'h01, 16'h1234, 1'b0, 8'h00}, 1'b1, ST_FILL, 8'h01);
    add_row({1'b1, 8'h00, 16'h0000, 1'b0, 8'h00}, 1'b1, ST_RELEASE, 8'h00);
    add_row({1'b1, 8'hFF, 16'hFFFF, 1'b0, 8'h00}, 1'b1, ST_RELEASE, 8'h00);
    add_row({1'b0, 8'h80, 16'h7FFF, 1'b0, 8'h80}, 1'b1, ST_FILL, 8'h00);
    add_row({1'b0, 8'h77, 16'hAAAA, 1'b1, 8'h02}, 1'b0, ST_HIT, 8'h00);
    add_row({1'b1, 8'hA5, 16'h5555, 1'b1, 8'h03}, 1'b1, ST_RELEASE, 8'h03);
    add_row({1'b0, 8'hA5, 16'h5AA5, 1'b1, 8'h03}, 1'b1, ST_HIT, 8'h03);
    add_row({1'b0, 8'hA5, 16'h5AA5, 1'b0, 8'h03}, 1'b0, ST_HIT, 8'h00);
    add_row({1'b0, 8'hA5, 16'h5AA6, 1'b1, 8'h03}, 1'b0, ST_HIT, 8'h00);
    add_row({1'b1, 8'h00, 16'h0001, 1'b0, 8'h80}, 1'b1, ST_RELEASE, 8'h80);
    add_row({1'b0, 8'hFF, 16'h0000, 1'b0, 8'h00}, 1'b0, ST_HIT, 8'h00);

    foreach (page_rows[k]) begin
      row = page_rows[k];
      offer_page(row.req, row.typed, row.rsp);
    end

    // one owner takes every frame: its next miss has no victim, and a
    // foreign miss must clear every reference bit and wrap back to frame 0
    calm = 1'b1;
    for (f = 0; f < NUM_FRAMES; f++) begin
      if (pt_valid[f] && pt_proc[f] != SOLO_PROC) begin
        rq = rand_req();
        rq.mode = 1'b1;
        rq.frame = f[7:0];
        offer_page(rq, 1'b0, '0);
      end
    end
    while (pt_free > 0) begin
      rq = rand_req();
      rq.mode = 1'b0;
      rq.resident = 1'b0;
      rq.proc = SOLO_PROC;
      offer_page(rq, 1'b0, '0);
    end
    rq = rand_req();
    rq.mode = 1'b0;
    rq.resident = 1'b0;
    rq.proc = SOLO_PROC;
    offer_page(rq, 1'b0, '0);
    rq.proc = OTHER_PROC;
    offer_page(rq, 1'b0, '0);
    calm = 1'b0;

    // mixed traffic, mostly from a few processes so own-frame skips are common
    for (k = 0; k < MAIN_ITEMS; k++) begin
      calm = (k >= 600 && k < 700);
      rq = rand_req();
      r = $urandom_range(0, 99);
      if (r < 50) begin
        rq.mode = 1'b0;
        rq.resident = 1'b0;
        if ($urandom_range(0, 4) != 0) rq.proc = 8'($urandom_range(0, 5));
      end else if (r < 75) begin
        rq.mode = 1'b0;
        rq.resident = 1'b1;
        if ($urandom_range(0, 6) != 0) rq.frame = pick_held_frame();
      end else if (r < 95) begin
        rq.mode = 1'b1;
        if ($urandom_range(0, 6) != 0) rq.frame = pick_held_frame();
      end
      offer_page(rq, 1'b0, '0);
    end
    calm = 1'b0;

    // free the whole table again
    while (pt_free < NUM_FRAMES) begin
      rq = rand_req();
      rq.mode = 1'b1;
      rq.frame = pick_held_frame();
      offer_page(rq, 1'b0, '0);
    end

    @(posedge clk);
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run: %0d request beats, %0d result beats; hits %0d, fills %0d, replacements %0d",
             beats_sent, beats_seen, status_seen[ST_HIT], status_seen[ST_FILL],
             status_seen[ST_REPLACE]);
    $display("No-victim %0d, releases %0d, one %0d-cycle result hold-off, %0d mismatches",
             status_seen[ST_NOVICTIM], status_seen[ST_RELEASE], HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
